// File: rtl/eetp_pkg.sv
package eetp_pkg;

    localparam int TIME_W     = 32;
    localparam int PPR_W      = 14;
    localparam int POS_W      = 16;
    localparam int FREQ_W     = 28;
    localparam int DUTY_W     = 17;
    localparam int DUTY_FRAC  = 16;
    localparam int CFG_DATA_W = 32;

    localparam logic [PPR_W-1:0]  PPR_MAX    = 14'd16383;
    localparam logic [TIME_W-1:0] FREQ_SCALE = 32'd256000000;
    localparam logic [DUTY_W-1:0] DUTY_ONE   = 17'h10000;

    // dividend widths of the two serial dividers
    localparam int FREQ_NUM_W = TIME_W;
    localparam int DUTY_NUM_W = TIME_W + DUTY_FRAC + 1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 160;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_POLL = 1'b1
    } opcode_t;

    typedef enum logic {
        CFG_PPR     = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic accept;
        logic edge_ld;
        logic div_start;
        logic res_ld;
        logic out_ld;
    } ctrl_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: rtl/encoder_edge_timer_position_top.sv
// An edge with a nonzero period passes from input transfer to output valid through PREP, DIV and FIN;
// in DIV the two 28-bit and 17-bit serial dividers run side by side, one bit per cycle.
// A zero-period edge skips DIV and a poll goes straight to FIN; the next item is taken in the
// cycle after the result is loaded, so no new item is taken while one is still in progress.
// The output register lets the next item enter while a result waits for m_tready.
// Reset (rst_n low, asynchronous) clears all measurement state and loads 100 and 500000.
module encoder_edge_timer_position_top
    import eetp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] level_a, [1] level_b, [33:2] time_us
    input  logic                   s_tuser,   // [0] opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] position, [47:16] high_time_us, [79:48] low_time_us, [111:80] period_us,
    // [139:112] freq_q8, [156:140] duty_q16, [157] stopped
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    eetp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    eetp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/eetp_div.sv
module eetp_div
    import eetp_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int QUO_W = 28,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] shq_reg, shq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle; the upper dividend bits
    // are already below the divisor because the quotient fits in QUO_W bits
    assign trial = {rem_reg, shq_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next = rem_reg;
        shq_next = shq_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = DEN_W'(num[NUM_W-1:QUO_W]);
            shq_next = num[QUO_W-1:0];
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            shq_next = {shq_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = shq_reg;

endmodule

// File: rtl/eetp_ctrl.sv
module eetp_ctrl
    import eetp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tuser,   // [0] opcode
    output logic         s_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (opcode_t'(s_tuser) == OP_EDGE) ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP:
            begin
                state_next = status.period_zero ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.accept  = s_tvalid;
                cmd.edge_ld = s_tvalid && (opcode_t'(s_tuser) == OP_EDGE);
            end
            ST_PREP:
            begin
                cmd.div_start = !status.period_zero;
            end
            ST_DIV:
            begin
                cmd.res_ld = !status.div_busy;
            end
            ST_FIN:
            begin
                cmd.out_ld = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/eetp_dp.sv
module eetp_dp
    import eetp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // level_a, level_b, time_us[31:0], zero pad
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ctrl_cmd_t              cmd,
    output ctrl_status_t           status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int C_W = POS_W + 3;

    logic [TIME_W-1:0]      time_reg;
    logic                   a_level_reg;
    logic [TIME_W-1:0]      last_edge_reg;
    logic [TIME_W-1:0]      high_reg;
    logic [TIME_W-1:0]      low_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [DUTY_W-1:0]      duty_reg;
    logic [POS_W-1:0]       count_reg, count_next;
    logic [PPR_W-1:0]       ppr_reg;
    logic [TIME_W-1:0]      timeout_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_valid_reg;

    logic                   in_a;
    logic                   in_b;
    logic [TIME_W-1:0]      in_time;
    logic [TIME_W-1:0]      dt;
    logic [PPR_W-1:0]       ppr_sat;
    logic signed [C_W-1:0]  c_step;
    logic signed [C_W-1:0]  ppr_s;
    logic signed [C_W-1:0]  c_wrap;

    logic [TIME_W:0]        sum;
    logic [TIME_W-1:0]      period;
    logic                   high_ge;
    logic [FREQ_NUM_W-1:0]  freq_num;
    logic [DUTY_NUM_W-1:0]  duty_num;
    logic [FREQ_W-1:0]      freq_quo;
    logic [DUTY_W-1:0]      duty_quo;
    logic                   busy_f;
    logic                   busy_d;

    logic [TIME_W-1:0]      elapsed;
    logic                   stopped;
    logic [FREQ_W-1:0]      freq_o;
    logic [DUTY_W-1:0]      duty_o;
    logic [DUTY_W-1:0]      duty_stop;

    assign in_a    = s_tdata[0];
    assign in_b    = s_tdata[1];
    assign in_time = s_tdata[TIME_W+1:2];
    assign dt      = in_time - last_edge_reg;

    // position step with a single wrap correction
    assign ppr_sat = (ppr_reg > PPR_MAX) ? PPR_MAX : ppr_reg;
    assign ppr_s   = signed'(C_W'(ppr_sat));
    assign c_step  = signed'(C_W'(signed'(count_reg)))
                     + ((in_a == in_b) ? C_W'(1) : -C_W'(1));

    always_comb
    begin
        c_wrap = c_step;
        if (c_step > ppr_s)
        begin
            c_wrap = c_step - (ppr_s <<< 1);
        end
        else if (c_step < -ppr_s)
        begin
            c_wrap = c_step + (ppr_s <<< 1);
        end
        count_next = (ppr_sat == '0) ? '0 : c_wrap[POS_W-1:0];
    end

    assign sum      = {1'b0, high_reg} + {1'b0, low_reg};
    assign period   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    assign high_ge  = (high_reg >= period);
    assign freq_num = FREQ_SCALE + {1'b0, period[TIME_W-1:1]};
    assign duty_num = {1'b0, high_reg, {DUTY_FRAC{1'b0}}}
                      + DUTY_NUM_W'(period[TIME_W-1:1]);

    eetp_div #(
        .NUM_W (FREQ_NUM_W),
        .QUO_W (FREQ_W),
        .DEN_W (TIME_W)
    ) u_div_freq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (freq_num),
        .den   (period),
        .busy  (busy_f),
        .quo   (freq_quo)
    );

    eetp_div #(
        .NUM_W (DUTY_NUM_W),
        .QUO_W (DUTY_W),
        .DEN_W (TIME_W)
    ) u_div_duty (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (duty_num),
        .den   (period),
        .busy  (busy_d),
        .quo   (duty_quo)
    );

    assign elapsed   = time_reg - last_edge_reg;
    assign stopped   = (elapsed >= timeout_reg);
    assign duty_stop = a_level_reg ? DUTY_ONE : '0;
    assign freq_o    = stopped ? '0 : freq_reg;
    assign duty_o    = stopped ? duty_stop : duty_reg;

    assign status.period_zero = (period == '0);
    assign status.div_busy    = busy_f | busy_d;
    assign status.out_free    = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_level_reg   <= 1'b0;
            last_edge_reg <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            freq_reg      <= '0;
            duty_reg      <= '0;
            count_reg     <= '0;
            ppr_reg       <= PPR_W'(100);
            timeout_reg   <= TIME_W'(500000);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index_t'(cfg_index) == CFG_PPR)
                begin
                    ppr_reg <= cfg_data[PPR_W-1:0];
                end
                else
                begin
                    timeout_reg <= cfg_data[TIME_W-1:0];
                end
            end
            if (cmd.edge_ld)
            begin
                a_level_reg   <= in_a;
                last_edge_reg <= in_time;
                count_reg     <= count_next;
                if (in_a)
                begin
                    low_reg <= dt;
                end
                else
                begin
                    high_reg <= dt;
                end
            end
            if (cmd.res_ld)
            begin
                freq_reg <= freq_quo;
                duty_reg <= high_ge ? DUTY_ONE : duty_quo;
            end
            if (cmd.out_ld)
            begin
                freq_reg      <= freq_o;
                duty_reg      <= duty_o;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            time_reg <= in_time;
        end
        if (cmd.out_ld)
        begin
            out_data_reg <= OUT_TDATA_W'({stopped, duty_o, freq_o, period,
                                          low_reg, high_reg, count_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: bench/encoder_edge_timer_position_top_test.sv
`timescale 1ns / 100ps

module encoder_edge_timer_position_top_test;
    import eetp_pkg::*;

    localparam int EDGES_PER_PHASE = 305;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        opcode_t           op;
        logic              lvl_a;
        logic              lvl_b;
        logic [TIME_W-1:0] stamp;
    } encoder_event_t;

    typedef struct {
        logic [POS_W-1:0]  position;
        logic [TIME_W-1:0] high_us;
        logic [TIME_W-1:0] low_us;
        logic [TIME_W-1:0] period_us;
        logic [FREQ_W-1:0] freq_q8;
        logic [DUTY_W-1:0] duty_q16;
        logic              stopped;
    } meter_reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predicted block state and register copies
    logic [PPR_W-1:0]  ppr_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic              a_now;
    logic [TIME_W-1:0] last_edge_us;
    logic [TIME_W-1:0] high_us;
    logic [TIME_W-1:0] low_us;
    logic [FREQ_W-1:0] freq_q8;
    logic [DUTY_W-1:0] duty_q16;
    logic [POS_W-1:0]  position;

    encoder_event_t pending_events[$];
    meter_reading_t expected_readings[$];
    encoder_event_t drive_ev;
    encoder_event_t seen_ev;
    meter_reading_t got;
    meter_reading_t want;

    logic              stim_taken;
    int                items_queued;
    int                items_accepted;
    int                err_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    logic [TIME_W-1:0] gen_time;
    logic              gen_a;
    logic              gen_dir;

    encoder_edge_timer_position_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("encoder_edge_timer_position_top regression: fail");
        $finish;
    end

    function automatic logic [TIME_W-1:0] period_now();
        logic [TIME_W:0] sum;
        sum = {1'b0, high_us} + {1'b0, low_us};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic meter_reading_t meter_predict(encoder_event_t ev);
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] per;
        logic [63:0]       num;
        int                ppr_i;
        int                pos_next;
        meter_reading_t    rd;
        rd.stopped = 1'b0;
        if (ev.op == OP_EDGE)
        begin
            dt           = ev.stamp - last_edge_us;
            a_now        = ev.lvl_a;
            last_edge_us = ev.stamp;
            ppr_i        = int'(ppr_reg);
            pos_next     = int'($signed(position)) + ((ev.lvl_a == ev.lvl_b) ? 1 : -1);
            if (ppr_i == 0)
                position = '0;
            else
            begin
                // one correction only, even if the count sits far outside the range
                if (pos_next > ppr_i)
                    pos_next -= 2 * ppr_i;
                else if (pos_next < -ppr_i)
                    pos_next += 2 * ppr_i;
                position = POS_W'(pos_next);
            end
            if (!a_now)
                high_us = dt;
            else
                low_us = dt;
            per = period_now();
            // hold frequency and duty on a zero period
            if (per != '0)
            begin
                num     = 64'(FREQ_SCALE) + 64'(per >> 1);
                freq_q8 = FREQ_W'(num / 64'(per));
                if (high_us >= per)
                    duty_q16 = DUTY_ONE;
                else
                begin
                    num      = (64'(high_us) << DUTY_FRAC) + 64'(per >> 1);
                    duty_q16 = DUTY_W'(num / 64'(per));
                end
            end
        end
        dt = ev.stamp - last_edge_us;
        if (dt >= timeout_reg)
        begin
            freq_q8    = '0;
            duty_q16   = a_now ? DUTY_ONE : '0;
            rd.stopped = 1'b1;
        end
        rd.position  = position;
        rd.high_us   = high_us;
        rd.low_us    = low_us;
        rd.period_us = period_now();
        rd.freq_q8   = freq_q8;
        rd.duty_q16  = duty_q16;
        return rd;
    endfunction

    // input side: present the next pending event once the previous transfer is done
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || stim_taken)
            begin
                stim_taken = 1'b0;
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drive_ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, drive_ev.stamp, drive_ev.lvl_b, drive_ev.lvl_a};
                    s_tuser  <= drive_ev.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check the output before predicting, so a result never meets its own item
            if (m_tvalid && m_tready)
            begin
                got.position  = m_tdata[15:0];
                got.high_us   = m_tdata[47:16];
                got.low_us    = m_tdata[79:48];
                got.period_us = m_tdata[111:80];
                got.freq_q8   = m_tdata[139:112];
                got.duty_q16  = m_tdata[156:140];
                got.stopped   = m_tdata[157];
                if (expected_readings.size() == 0)
                begin
                    if (err_count < 10)
                        $display("%0t: result with no pending expectation", $realtime);
                    err_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.position !== want.position || got.high_us !== want.high_us ||
                        got.low_us !== want.low_us || got.period_us !== want.period_us ||
                        got.freq_q8 !== want.freq_q8 || got.duty_q16 !== want.duty_q16 ||
                        got.stopped !== want.stopped)
                    begin
                        if (err_count < 10)
                        begin
                            $display("%0t: mismatch exp pos %0d hi %0d lo %0d per %0d",
                                     $realtime, $signed(want.position), want.high_us,
                                     want.low_us, want.period_us);
                            $display("    exp freq %0d duty %0d stopped %0b",
                                     want.freq_q8, want.duty_q16, want.stopped);
                            $display("    got pos %0d hi %0d lo %0d per %0d",
                                     $signed(got.position), got.high_us, got.low_us,
                                     got.period_us);
                            $display("    got freq %0d duty %0d stopped %0b",
                                     got.freq_q8, got.duty_q16, got.stopped);
                        end
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_ev.op    = opcode_t'(s_tuser);
                seen_ev.lvl_a = s_tdata[0];
                seen_ev.lvl_b = s_tdata[1];
                seen_ev.stamp = s_tdata[33:2];
                expected_readings.push_back(meter_predict(seen_ev));
                stim_taken = 1'b1;
                items_accepted++;
            end
        end
    end

    task automatic add_event(input opcode_t op, input logic lvl_a, input logic lvl_b,
                             input logic [TIME_W-1:0] stamp);
        encoder_event_t ev;
        ev.op    = op;
        ev.lvl_a = lvl_a;
        ev.lvl_b = lvl_b;
        ev.stamp = stamp;
        if (op == OP_EDGE)
        begin
            gen_time = stamp;
            gen_a    = lvl_a;
        end
        pending_events.push_back(ev);
        items_queued++;
    endtask

    // hold off new input until every transfer has its result, then let the block settle
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_PPR)
            ppr_reg = value[PPR_W-1:0];
        else
            timeout_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a clean quadrature-like edge train with polls near the timeout, plus noise
    task automatic gen_stream(input int n);
        int                pick;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] stamp;
        logic              lvl_a;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                case ($urandom_range(0, 19))
                    0:       gap = $urandom();
                    1, 2:    gap = $urandom_range(0, 3);
                    3, 4, 5: gap = $urandom_range(0, 1000000);
                    default: gap = $urandom_range(1, 2000);
                endcase
                if ($urandom_range(0, 15) == 0)
                    gen_dir = ~gen_dir;
                lvl_a = ~gen_a;
                add_event(OP_EDGE, lvl_a, gen_dir ? lvl_a : ~lvl_a, gen_time + gap);
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 4))
                    0:       stamp = gen_time + timeout_reg - 1;
                    1:       stamp = gen_time + timeout_reg;
                    2:       stamp = gen_time + $urandom_range(0, 3000);
                    default: stamp = $urandom();
                endcase
                add_event(OP_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), stamp);
            end
            else
            begin
                stamp = $urandom_range(0, 1) ? $urandom() : gen_time + $urandom_range(0, 50);
                add_event(opcode_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), stamp);
            end
        end
    endtask

    task automatic run_phase(input int mode, input logic [PPR_W-1:0] ppr,
                             input logic [TIME_W-1:0] tmo, input int n);
        wait_drained();
        write_reg(CFG_PPR, {18'($urandom()), ppr});
        write_reg(CFG_TIMEOUT, tmo);
        send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 87 : 0;
        recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 38 : 0;
        gen_stream(n);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_EDGE;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_PPR;
        cfg_data       = '0;
        stim_taken     = 1'b0;
        items_queued   = 0;
        items_accepted = 0;
        err_count      = 0;
        send_idle_pct  = 38;
        recv_idle_pct  = 87;
        gen_time       = '0;
        gen_a          = 1'b0;
        gen_dir        = 1'b1;
        ppr_reg        = 14'd100;
        timeout_reg    = 32'd500000;
        a_now          = 1'b0;
        last_edge_us   = '0;
        high_us        = '0;
        low_us         = '0;
        freq_q8        = '0;
        duty_q16       = '0;
        position       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero period right after reset, then normal intervals and the timeout boundary
        add_event(OP_EDGE, 1'b1, 1'b1, 32'd0);
        add_event(OP_POLL, 1'b0, 1'b0, 32'd0);
        add_event(OP_EDGE, 1'b0, 1'b1, 32'd1000);
        add_event(OP_EDGE, 1'b1, 1'b1, 32'd1250);
        add_event(OP_EDGE, 1'b0, 1'b0, 32'd1500);
        add_event(OP_POLL, 1'b1, 1'b1, 32'd1500 + 32'd499999);
        add_event(OP_POLL, 1'b0, 1'b1, 32'd1500 + 32'd500000);
        add_event(OP_POLL, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // timestamp wrap and period saturation
        add_event(OP_EDGE, 1'b1, 1'b0, 32'hFFFF_FFFF);
        add_event(OP_EDGE, 1'b0, 1'b0, 32'd0);
        add_event(OP_EDGE, 1'b1, 1'b1, 32'hFFFF_FFFE);
        add_event(OP_EDGE, 1'b0, 1'b0, 32'hFFFF_FFFD);
        // shortest period: full-scale frequency, high time equal to period
        add_event(OP_EDGE, 1'b1, 1'b1, 32'd100);
        add_event(OP_EDGE, 1'b0, 1'b1, 32'd101);
        add_event(OP_EDGE, 1'b1, 1'b1, 32'd101);
        wait_drained();

        // smallest wrap range and a zero timeout that stops even on an edge
        write_reg(CFG_PPR, {18'($urandom()), 14'd1});
        write_reg(CFG_TIMEOUT, 32'd0);
        add_event(OP_EDGE, 1'b0, 1'b0, 32'd200);
        add_event(OP_EDGE, 1'b1, 1'b1, 32'd300);
        add_event(OP_EDGE, 1'b0, 1'b0, 32'd400);
        add_event(OP_EDGE, 1'b1, 1'b0, 32'd500);
        add_event(OP_EDGE, 1'b0, 1'b1, 32'd600);
        add_event(OP_EDGE, 1'b1, 1'b0, 32'd700);
        wait_drained();

        // zero pulses per revolution pins the count
        write_reg(CFG_PPR, {18'($urandom()), 14'd0});
        add_event(OP_EDGE, 1'b0, 1'b0, 32'd800);
        add_event(OP_EDGE, 1'b1, 1'b0, 32'd900);
        add_event(OP_POLL, 1'b1, 1'b1, 32'd900);

        run_phase(0, 14'd16383, 32'hFFFF_FFFF, EDGES_PER_PHASE);
        run_phase(0, 14'd3, 32'd1000, EDGES_PER_PHASE);
        run_phase(1, 14'($urandom_range(1, 40)), $urandom_range(0, 2000), EDGES_PER_PHASE);
        run_phase(1, 14'd1, 32'd0, EDGES_PER_PHASE);
        run_phase(2, 14'd0, 32'd200000, EDGES_PER_PHASE);
        run_phase(2, 14'($urandom_range(1, 16383)), $urandom(), EDGES_PER_PHASE);
        wait_drained();

        if (err_count == 0)
            $display("encoder_edge_timer_position_top regression: pass");
        else
            $display("encoder_edge_timer_position_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/eetp_pkg.sv
rtl/eetp_div.sv
rtl/eetp_ctrl.sv
rtl/eetp_dp.sv
rtl/encoder_edge_timer_position_top.sv
bench/encoder_edge_timer_position_top_test.sv
